### sv/bar_pkg.sv
// ----------------------------------------------------------------------------
// bar_pkg
// shared constants and helpers for the button auto-repeat block
// ----------------------------------------------------------------------------
package bar_pkg;

	localparam int PLAYERS            = 2;
	localparam int BUTTONS_PER_PLAYER = 8;

	// mask layout: bit player*8+button
	localparam int LANE_STRIDE = 8;
	localparam int MASK_W      = 16;
	localparam int STAMP_W     = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;

	// stream payload widths (padded to whole bytes)
	localparam int S_DATA_W = ((STAMP_W + MASK_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((MASK_W + 7) / 8) * 8;

	localparam logic [15:0] DELAY_RESET    = 16'd400;
	localparam logic [15:0] INTERVAL_RESET = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPEAT_DELAY    = 1'b0,
		CFG_REPEAT_INTERVAL = 1'b1
	} cfg_idx_t;

	// lanes that belong to a configured player and button
	function automatic logic [MASK_W-1:0] lane_used_mask();
		logic [MASK_W-1:0] m;
		m = '0;
		for (int l = 0; l < MASK_W; l++) begin
			if ((l / LANE_STRIDE) < PLAYERS && (l % LANE_STRIDE) < BUTTONS_PER_PLAYER)
				m[l] = 1'b1;
		end
		return m;
	endfunction

	localparam logic [MASK_W-1:0] LANE_USED = lane_used_mask();

endpackage

### sv/button_auto_repeat.sv
// ----------------------------------------------------------------------------
// button_auto_repeat
// per-button typematic repeat: fresh press fires, held buttons repeat
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. Each input transfer carries a
// millisecond timestamp and the pressed mask of up to 16 buttons (bit
// player*8+button); the result is the fire mask for that scan. A fresh press
// fires at once; a held button fires again once repeat_delay_ms has passed
// since the press and then every repeat_interval_ms (differences modulo 2^32).
// The block takes one scan per clock unless output back-pressure stalls it.
// Each scan is first captured in the input register, then the sixteen
// parallel subtract-and-compare lanes update the per-button state and load
// the result register. Back-pressure on the output stalls the input register
// only once the result register is full. Write the delay and interval
// registers only while no scan is in flight.
// ----------------------------------------------------------------------------
module button_auto_repeat (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bar_pkg::S_DATA_W-1:0]      s_tdata,   // [31:0] now_ms, [47:32] pressed_mask
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bar_pkg::M_DATA_W-1:0]      m_tdata,   // [15:0] fire_mask
	// configuration writes
	input  logic                              cfg_we,
	input  logic [bar_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bar_pkg::CFG_W-1:0]         cfg_data
);
	import bar_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] delay_q;
	logic [CFG_W-1:0] interval_q;

	// input register
	logic               valid_s1;
	logic [STAMP_W-1:0] now_s1;
	logic [MASK_W-1:0]  mask_s1;

	// result register
	logic               valid_s2;
	logic [MASK_W-1:0]  fire_s2;

	// per-button state
	logic [MASK_W-1:0]  held_q;
	logic [STAMP_W-1:0] press_q  [MASK_W];
	logic [STAMP_W-1:0] repeat_q [MASK_W];

	logic               advance;
	logic [MASK_W-1:0]  fire_c;
	logic [MASK_W-1:0]  fresh_c;

	// the input register moves on when the result register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = valid_s2;
	assign m_tdata  = M_DATA_W'(fire_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= DELAY_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_REPEAT_DELAY:    delay_q    <= cfg_data;
				CFG_REPEAT_INTERVAL: interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1  <= s_tdata[STAMP_W-1:0];
			mask_s1 <= s_tdata[STAMP_W +: MASK_W];
		end
	end

	// sixteen lanes, each with two wrapped subtracts and compares per stamp
	always_comb begin
		logic [STAMP_W-1:0] since_press;
		logic [STAMP_W-1:0] since_fire;
		for (int l = 0; l < MASK_W; l++) begin
			since_press = now_s1 - press_q[l];
			since_fire  = now_s1 - repeat_q[l];
			fresh_c[l]  = LANE_USED[l] && mask_s1[l] && !held_q[l];
			fire_c[l]   = LANE_USED[l] && mask_s1[l] && (!held_q[l] ||
				(since_press >= STAMP_W'(delay_q) && since_fire >= STAMP_W'(interval_q)));
		end
	end

	// state update happens with the result load, so the next scan sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (advance) begin
			held_q <= mask_s1 & LANE_USED;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < MASK_W; l++) begin
				if (fresh_c[l])
					press_q[l] <= now_s1;
				if (fire_c[l])
					repeat_q[l] <= now_s1;
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			fire_s2 <= fire_c;
	end

	// unconfigured lanes never fire
	a_unused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (fire_s2 & ~LANE_USED) == '0)
		else $error("fire on an unconfigured lane");

	// every fresh press shows up in the next result
	a_fresh_fires: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (fire_s2 & $past(fresh_c)) == $past(fresh_c))
		else $error("fresh press did not fire");

	// held flags follow the scan just consumed
	a_held_track: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> held_q == ($past(mask_s1) & LANE_USED))
		else $error("held flags out of step with last scan");

	// a result never appears for a button that is up
	a_fire_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (fire_s2 & ~held_q) == '0)
		else $error("fire on a released button");

endmodule
